[hdl/random_color_zone_painter_defines.svh]
// assertion macros shared by the zone painter
`ifndef RANDOM_COLOR_ZONE_PAINTER_DEFINES_SVH
`define RANDOM_COLOR_ZONE_PAINTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RCZP_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("zone painter check failed");

// next-cycle implication, checked out of reset
`define RCZP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("zone painter check failed");

`endif

[hdl/rczp_pkg.sv]
// shared types, constants and the hue wheel for the zone painter
package rczp_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_DIV_Z,
        ST_COL,
        ST_STEP,
        ST_EMIT
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start_n;
        logic start_z;
        logic setup;
        logic step_begin;
        logic step;
        logic emit;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic need_step;
        logic distinct;
        logic out_free;
        logic last_col;
    } dp_status_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // configuration register indexes
    localparam logic [1:0] REG_SPEED     = 2'd0;
    localparam logic [1:0] REG_INTENSITY = 2'd1;
    localparam logic [1:0] REG_SEED      = 2'd2;

    localparam logic [7:0]  SPEED_RESET     = 8'd128;
    localparam logic [7:0]  INTENSITY_RESET = 8'd128;
    localparam logic [15:0] SEED_RESET      = 16'd1;

    // generator and timing constants
    localparam logic [31:0] LCG_MUL       = 32'd2053;
    localparam logic [31:0] LCG_INC       = 32'd13849;
    localparam logic [7:0]  MIN_HUE_STEP  = 8'd42;
    localparam logic [9:0]  PERIOD_BASE   = 10'd25;

    // six-sector full-saturation wheel, t = hue*6 split by 255
    function automatic rgb_t hue_to_rgb(input logic [7:0] hue);
        logic [10:0] t;
        logic [2:0]  sec;
        logic [10:0] base;
        logic [7:0]  r;
        rgb_t        c;
        t = 11'({3'b000, hue} * 11'd6);
        if (t >= 11'd1275) begin
            sec  = 3'd5;
            base = 11'd1275;
        end else if (t >= 11'd1020) begin
            sec  = 3'd4;
            base = 11'd1020;
        end else if (t >= 11'd765) begin
            sec  = 3'd3;
            base = 11'd765;
        end else if (t >= 11'd510) begin
            sec  = 3'd2;
            base = 11'd510;
        end else if (t >= 11'd255) begin
            sec  = 3'd1;
            base = 11'd255;
        end else begin
            sec  = 3'd0;
            base = 11'd0;
        end
        // top of the wheel lands on r = 255 in the last sector
        r = 8'(t - base);
        case (sec)
            3'd0:
            begin
                c = '{red: 8'd255, green: r, blue: 8'd0};
            end
            3'd1:
            begin
                c = '{red: 8'd255 - r, green: 8'd255, blue: 8'd0};
            end
            3'd2:
            begin
                c = '{red: 8'd0, green: 8'd255, blue: r};
            end
            3'd3:
            begin
                c = '{red: 8'd0, green: 8'd255 - r, blue: 8'd255};
            end
            3'd4:
            begin
                c = '{red: r, green: 8'd0, blue: 8'd255};
            end
            default:
            begin
                c = '{red: 8'd255, green: 8'd0, blue: 8'd255 - r};
            end
        endcase
        return c;
    endfunction

endpackage

[hdl/random_color_zone_painter.sv]
// Random color zone painter: each frame time item yields COLUMNS colored column items,
// highest column first. An item first finds the interval number and then its zone offset
// (one shared divider, one quotient bit per cycle), then passes through a column state and
// an emit state per column, with generator steps at each zone boundary, retried until the
// hue is far enough from the last one, and waits on any output stall. A new frame is
// accepted as soon as the last column sits in the output register. Configuration writes are
// taken in any cycle; there is no clearing pass after reset.
`include "random_color_zone_painter_defines.svh"

module random_color_zone_painter #(
    parameter int COLUMNS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] time_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  column,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_column
);

    rczp_pkg::dp_cmd_t    cmd;
    rczp_pkg::dp_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    rczp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rczp_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .time_ms     (time_ms),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .column      (column),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_column (last_column)
    );

    // an emitted column shows up as a valid item
    `RCZP_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)
    // a frame keeps the input closed once accepted
    `RCZP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
    // the final column reopens the input with the last item on display
    `RCZP_ASSERT_NEXT(a_last_reopens, cmd.emit && status.last_col, in_ready && out_valid && last_column)
    // a generator search never starts while the input is open
    `RCZP_ASSERT_IMPL(a_step_busy, cmd.step_begin || cmd.step, !in_ready)

endmodule

[hdl/rczp_div.sv]
// restoring divider, one quotient bit per cycle
module rczp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [9:0]  remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  dsr_reg, dsr_next;
    logic [10:0] trial;
    logic        fits;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    // next values
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = dividend;
            rem_next  = 10'd0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? 10'(trial - {1'b0, dsr_reg}) : trial[9:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/rczp_dp.sv]
// datapath: config registers, divider, generator, zone tracking, output register
module rczp_dp #(
    parameter int COLUMNS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [31:0]         time_ms,
    input  rczp_pkg::dp_cmd_t   cmd,
    output rczp_pkg::dp_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [5:0]          column,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic                last_column
);

    localparam logic [9:0] PERIOD_BASE_W = rczp_pkg::PERIOD_BASE;

    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  intensity_reg, intensity_next;
    logic [15:0] seed_reg, seed_next;
    logic [15:0] saved_lcg_reg, saved_lcg_next;
    logic [15:0] last_interval_reg, last_interval_next;
    logic        seeded_reg, seeded_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] n_reg, n_next;
    logic [4:0]  z_reg, z_next;
    logic [5:0]  col_reg, col_next;
    logic        fresh_reg, fresh_next;
    logic [15:0] gen_reg, gen_next;
    logic [7:0]  prev_hi_reg, prev_hi_next;
    logic [5:0]  column_reg, column_next;
    rczp_pkg::rgb_t rgb_reg, rgb_next;
    logic        last_reg, last_next;

    logic [7:0]  speed_inv;
    logic [9:0]  period;
    logic [4:0]  zsize;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [9:0]  div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;
    logic [9:0]  div_remainder;
    logic [15:0] lcg_next;
    logic [7:0]  hi_new;
    logic [7:0]  hi_diff;
    logic        distinct;

    // interval length and zone size from the registers
    assign speed_inv = ~speed_reg;
    assign period    = PERIOD_BASE_W + {1'b0, speed_inv, 1'b0} + {2'b00, speed_inv};
    assign zsize     = {1'b0, ~intensity_reg[7:4]} + 5'd1;

    // shared divider: frame time by interval, then interval by zone size
    assign div_start    = cmd.start_n | cmd.start_z;
    assign div_dividend = cmd.start_z ? div_quotient : time_ms;
    assign div_divisor  = cmd.start_z ? {5'd0, zsize} : period;

    rczp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // one generator step and the distance test on its high byte
    assign lcg_next = 16'(({16'd0, gen_reg} * rczp_pkg::LCG_MUL) + rczp_pkg::LCG_INC);
    assign hi_new   = lcg_next[15:8];
    assign hi_diff  = (hi_new >= prev_hi_reg) ? (hi_new - prev_hi_reg) : (prev_hi_reg - hi_new);
    assign distinct = hi_diff >= rczp_pkg::MIN_HUE_STEP;

    // status to the controller
    assign status.div_done  = div_done;
    assign status.need_step = fresh_reg | (z_reg >= zsize);
    assign status.distinct  = distinct;
    assign status.out_free  = ~out_valid_reg | out_ready;
    assign status.last_col  = (col_reg == 6'd0);

    // next values
    always_comb
    begin
        speed_next         = speed_reg;
        intensity_next     = intensity_reg;
        seed_next          = seed_reg;
        saved_lcg_next     = saved_lcg_reg;
        last_interval_next = last_interval_reg;
        seeded_next        = seeded_reg;
        out_valid_next     = out_valid_reg;
        n_next             = n_reg;
        z_next             = z_reg;
        col_next           = col_reg;
        fresh_next         = fresh_reg;
        gen_next           = gen_reg;
        prev_hi_next       = prev_hi_reg;
        column_next        = column_reg;
        rgb_next           = rgb_reg;
        last_next          = last_reg;

        // configuration writes
        if (cfg_write) begin
            unique case (cfg_index)
                rczp_pkg::REG_SPEED:     speed_next     = cfg_data[7:0];
                rczp_pkg::REG_INTENSITY: intensity_next = cfg_data[7:0];
                rczp_pkg::REG_SEED:      seed_next      = cfg_data;
                default:                 seed_next      = seed_reg;
            endcase
        end

        // interval number is ready when the zone division starts
        if (cmd.start_z) begin
            n_next = div_quotient;
        end

        // frame setup once the zone offset is known
        if (cmd.setup) begin
            col_next   = 6'(COLUMNS - 1);
            z_next     = div_remainder[4:0];
            fresh_next = (div_remainder == 10'd0) && (n_reg != {16'd0, last_interval_reg});
            if (seeded_reg) begin
                gen_next = saved_lcg_reg;
            end else begin
                gen_next       = seed_reg;
                saved_lcg_next = seed_reg;
            end
        end

        if (cmd.step_begin) begin
            prev_hi_next = gen_reg[15:8];
        end

        // search for a color far enough from the last one
        if (cmd.step) begin
            gen_next = lcg_next;
            if (distinct) begin
                if (fresh_reg) begin
                    saved_lcg_next = lcg_next;
                end
                fresh_next = 1'b0;
                z_next     = 5'd0;
            end
        end

        // output register
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            column_next    = col_reg;
            rgb_next       = rczp_pkg::hue_to_rgb(gen_reg[15:8]);
            last_next      = (col_reg == 6'd0);
            z_next         = z_reg + 5'd1;
            col_next       = col_reg - 6'd1;
            if (col_reg == 6'd0) begin
                last_interval_next = n_reg[15:0];
                seeded_next        = 1'b1;
            end
        end
    end

    // state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            speed_reg         <= rczp_pkg::SPEED_RESET;
            intensity_reg     <= rczp_pkg::INTENSITY_RESET;
            seed_reg          <= rczp_pkg::SEED_RESET;
            saved_lcg_reg     <= 16'd0;
            last_interval_reg <= 16'd0;
            seeded_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            speed_reg         <= speed_next;
            intensity_reg     <= intensity_next;
            seed_reg          <= seed_next;
            saved_lcg_reg     <= saved_lcg_next;
            last_interval_reg <= last_interval_next;
            seeded_reg        <= seeded_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        z_reg       <= z_next;
        col_reg     <= col_next;
        fresh_reg   <= fresh_next;
        gen_reg     <= gen_next;
        prev_hi_reg <= prev_hi_next;
        column_reg  <= column_next;
        rgb_reg     <= rgb_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign column      = column_reg;
    assign red         = rgb_reg.red;
    assign green       = rgb_reg.green;
    assign blue        = rgb_reg.blue;
    assign last_column = last_reg;

endmodule

[hdl/rczp_ctrl.sv]
// controller: frame sequencing over divisions, generator search and column output
module rczp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rczp_pkg::dp_status_t status,
    output rczp_pkg::dp_cmd_t    cmd
);

    rczp_pkg::ctrl_state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rczp_pkg::ST_IDLE:
            begin
                if (in_valid) state_next = rczp_pkg::ST_DIV_N;
            end
            rczp_pkg::ST_DIV_N:
            begin
                if (status.div_done) state_next = rczp_pkg::ST_DIV_Z;
            end
            rczp_pkg::ST_DIV_Z:
            begin
                if (status.div_done) state_next = rczp_pkg::ST_COL;
            end
            rczp_pkg::ST_COL:
            begin
                state_next = status.need_step ? rczp_pkg::ST_STEP : rczp_pkg::ST_EMIT;
            end
            rczp_pkg::ST_STEP:
            begin
                if (status.distinct) state_next = rczp_pkg::ST_EMIT;
            end
            rczp_pkg::ST_EMIT:
            begin
                if (status.out_free) begin
                    state_next = status.last_col ? rczp_pkg::ST_IDLE : rczp_pkg::ST_COL;
                end
            end
            default:
            begin
                state_next = rczp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            rczp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.start_n = in_valid;
            end
            rczp_pkg::ST_DIV_N:
            begin
                cmd.start_z = status.div_done;
            end
            rczp_pkg::ST_DIV_Z:
            begin
                cmd.setup = status.div_done;
            end
            rczp_pkg::ST_COL:
            begin
                cmd.step_begin = status.need_step;
            end
            rczp_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
            end
            rczp_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= rczp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
